// ===== design/pid_pkg.sv =====
// ----------------------------------------------------------------------------
// pid_pkg
// Shared types, codes and helpers for the particle integrator with drag.
// ----------------------------------------------------------------------------
package pid_pkg;

  localparam logic [46:0] WIDE_MAX = 47'h7FFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    REQ_STEP    = 2'd0,
    REQ_IMPULSE = 2'd1,
    REQ_LOAD    = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    CFG_IN_FLUID = 3'd0,
    CFG_LAMINAR  = 3'd1,
    CFG_DRAG     = 3'd2,
    CFG_MASS     = 3'd3,
    CFG_EXT_FX   = 3'd4,
    CFG_EXT_FY   = 3'd5,
    CFG_EXT_FZ   = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    L_IDLE, L_SQ, L_WAITC, L_FORCE, L_FORCE2, L_FORCEW, L_DIVSET,
    L_DIV, L_DIVEND, L_DV, L_DV2, L_HALF, L_UPD, L_DONE
  } lane_state_e;

  typedef enum logic [2:0] {
    T_IDLE, T_SQWAIT, T_SQGO, T_SQRT, T_CMUL, T_CRND, T_CGO, T_WAIT
  } top_state_e;

  typedef struct packed {
    logic        start;
    req_e        op;
    logic        ack;
    logic        c_valid;
    logic [46:0] c;
    logic        in_fluid;
    logic        laminar;
    logic [30:0] k;
    logic [30:0] mass;
    logic [15:0] dt;
  } lane_ctrl_t;

  typedef struct packed {
    logic               sq_done;
    logic               done;
    logic [63:0]        sq;
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic               sat;
  } lane_stat_t;

  function automatic logic ovf32(logic signed [48:0] x);
    return (x > 49'sd2147483647) || (x < -49'sd2147483648);
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [48:0] x);
    if (x > 49'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -49'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

endpackage

// ===== design/pid_isqrt.sv =====
// ----------------------------------------------------------------------------
// pid_isqrt
// Iterative integer square root, one result bit per cycle for a 32-bit root.
// ----------------------------------------------------------------------------
module pid_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  import pid_pkg::*;

  logic [63:0] x_q, res_q, bit_q;
  logic        busy_q;
  logic [63:0] trial;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      res_q <= '0;
      bit_q <= 64'd1 << 62;
    end else if (busy_q && bit_q != '0) begin
      if (x_q >= trial) begin
        x_q   <= x_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = busy_q && (bit_q == '0);
  assign root_o = res_q[31:0];

endmodule

// ===== design/pid_lane.sv =====
// ----------------------------------------------------------------------------
// pid_lane
// One axis of the integrator: holds position and velocity, forms the force,
// divides by mass and applies the Euler update; also applies impulses and loads.
// ----------------------------------------------------------------------------
module pid_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pid_pkg::lane_ctrl_t ctrl_i,
  input  logic signed [31:0]  force_i,
  input  logic signed [31:0]  vec_i,
  output pid_pkg::lane_stat_t stat_o
);
  import pid_pkg::*;

  lane_state_e        st_q, st_d;
  logic signed [31:0] pos_q, pos_d, vel_q, vel_d;
  logic               sat_q, sat_d;
  logic [63:0]        prod_q;
  logic [47:0]        acc_q;
  logic [46:0]        fm_q, am_q, dvm_q;
  logic               fneg_q;
  logic [63:0]        div_q;
  logic [31:0]        rem_q;
  logic [5:0]         cnt_q;
  logic [62:0]        wprod_q;
  logic [31:0]        vm_q;

  logic [31:0] vmag, fext_mag, mul_a, mul_b;
  logic [63:0] mul_p, p64, num;
  logic [46:0] wa;
  logic [62:0] wprod;
  logic        vneg, vpos, p_big;
  logic [32:0] rem_sh, rem_n;
  logic        ge;
  logic [45:0] hm;
  logic signed [48:0] psum, vsum, isum, vdt_w, half_w, dv_w;

  assign vmag     = vel_q[31] ? 32'(-vel_q) : 32'(vel_q);
  assign vneg     = vel_q[31];
  assign vpos     = !vel_q[31] && (vel_q != '0);
  assign fext_mag = force_i[31] ? 32'(-force_i) : 32'(force_i);

  always_comb begin
    mul_a = '0;
    mul_b = vmag;
    case (st_q)
      L_SQ:     mul_a = vmag;
      L_FORCE:  mul_a = {1'b0, ctrl_i.k};
      L_WAITC:  mul_a = ctrl_i.c[31:0];
      L_FORCE2: mul_a = {17'b0, ctrl_i.c[46:32]};
      L_DV:     mul_a = {16'b0, ctrl_i.dt};
      default:  mul_a = '0;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign wa    = (st_q == L_HALF) ? dvm_q : am_q;
  assign wprod = wa * ctrl_i.dt;

  // turbulent: c_hi part shifted back up plus rounded c_lo part
  assign p64   = ctrl_i.laminar ? ({16'b0, prod_q[63:16]} + 64'(prod_q[15]))
                                : ({prod_q[47:0], 16'b0} + {16'b0, acc_q});
  assign p_big = p64 > 64'(WIDE_MAX);

  assign num    = {1'b0, fm_q, 16'b0} + {34'b0, ctrl_i.mass[30:1]};
  assign rem_sh = {rem_q, div_q[63]};
  assign ge     = rem_sh >= {2'b0, ctrl_i.mass};
  assign rem_n  = ge ? (rem_sh - {2'b0, ctrl_i.mass}) : rem_sh;

  assign hm     = wprod_q[62:17] + 46'(wprod_q[16]);
  assign vdt_w  = vneg ? -$signed({17'b0, vm_q}) : $signed({17'b0, vm_q});
  assign half_w = fneg_q ? -$signed({3'b0, hm}) : $signed({3'b0, hm});
  assign dv_w   = fneg_q ? -$signed({2'b0, dvm_q}) : $signed({2'b0, dvm_q});
  assign psum   = 49'(pos_q) + vdt_w + half_w;
  assign vsum   = 49'(vel_q) + dv_w;
  assign isum   = 49'(vel_q) + 49'(vec_i);

  always_comb begin
    st_d  = st_q;
    pos_d = pos_q;
    vel_d = vel_q;
    sat_d = sat_q;
    unique case (st_q)
      L_IDLE: begin
        if (ctrl_i.start) begin
          sat_d = 1'b0;
          unique case (ctrl_i.op)
            REQ_STEP: begin
              if (!ctrl_i.in_fluid) st_d = L_DIVSET;
              else if (ctrl_i.laminar) st_d = L_FORCE;
              else st_d = L_SQ;
            end
            REQ_IMPULSE: begin
              vel_d = sat32(isum);
              sat_d = ovf32(isum);
              st_d  = L_DONE;
            end
            REQ_LOAD: begin
              pos_d = vec_i;
              st_d  = L_DONE;
            end
            default: st_d = L_DONE;
          endcase
        end
      end
      L_SQ:     st_d = L_WAITC;
      L_WAITC:  if (ctrl_i.c_valid) st_d = L_FORCE2;
      L_FORCE2: st_d = L_FORCEW;
      L_FORCE:  st_d = L_FORCEW;
      L_FORCEW: begin
        if (p_big) sat_d = 1'b1;
        st_d = L_DIVSET;
      end
      L_DIVSET: begin
        if (ctrl_i.mass == '0) begin
          if (fm_q != '0) sat_d = 1'b1;
          st_d = L_DV;
        end else begin
          st_d = L_DIV;
        end
      end
      L_DIV:    if (&cnt_q) st_d = L_DIVEND;
      L_DIVEND: begin
        if (div_q[63:47] != '0) sat_d = 1'b1;
        st_d = L_DV;
      end
      L_DV:     st_d = L_DV2;
      L_DV2:    st_d = L_HALF;
      L_HALF:   st_d = L_UPD;
      L_UPD: begin
        pos_d = sat32(psum);
        vel_d = sat32(vsum);
        sat_d = sat_q | ovf32(psum) | ovf32(vsum);
        st_d  = L_DONE;
      end
      L_DONE:   if (ctrl_i.ack) st_d = L_IDLE;
      default:  st_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= L_IDLE;
      pos_q <= '0;
      vel_q <= '0;
    end else begin
      st_q  <= st_d;
      pos_q <= pos_d;
      vel_q <= vel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sat_q <= sat_d;
    case (st_q)
      L_IDLE: begin
        fm_q   <= {15'b0, fext_mag};
        fneg_q <= force_i[31];
      end
      L_SQ:     prod_q <= mul_p;
      L_WAITC:  if (ctrl_i.c_valid) prod_q <= mul_p;
      L_FORCE:  prod_q <= mul_p;
      L_FORCE2: begin
        acc_q  <= prod_q[63:16] + 48'(prod_q[15]);
        prod_q <= mul_p;
      end
      L_FORCEW: begin
        fm_q   <= p_big ? WIDE_MAX : p64[46:0];
        fneg_q <= vpos;  // drag opposes motion
      end
      L_DIVSET: begin
        div_q <= num;
        rem_q <= '0;
        cnt_q <= '0;
        am_q  <= (fm_q == '0) ? '0 : WIDE_MAX;
      end
      L_DIV: begin
        div_q <= {div_q[62:0], ge};
        rem_q <= rem_n[31:0];
        cnt_q <= cnt_q + 6'd1;
      end
      L_DIVEND: am_q <= (div_q[63:47] != '0) ? WIDE_MAX : div_q[46:0];
      L_DV: begin
        wprod_q <= wprod;
        prod_q  <= mul_p;
      end
      L_DV2: begin
        dvm_q <= wprod_q[62:16] + 47'(wprod_q[15]);
        vm_q  <= prod_q[47:16] + 32'(prod_q[15]);
      end
      L_HALF:   wprod_q <= wprod;
      default: ;
    endcase
  end

  assign stat_o.sq_done = (st_q == L_WAITC);
  assign stat_o.done    = (st_q == L_DONE);
  assign stat_o.sq      = prod_q;
  assign stat_o.pos     = pos_q;
  assign stat_o.vel     = vel_q;
  assign stat_o.sat     = sat_q;

endmodule

// ===== design/particle_integrator_with_drag_unit.sv =====
// ----------------------------------------------------------------------------
// particle_integrator_with_drag_unit
// Euler integrator for one particle in Q16.16 with external force or drag,
// three axis lanes side by side and a merge stage into the output register.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  s_axis    in   tuser: req_type; tdata: dt, vec_x, vec_y, vec_z
//  m_axis    out  tdata: pos_x/y/z, vel_x/y/z, saturated
//  cfg       in   write enable, register index, 32-bit data
//
//  impulse, load and unknown requests skip the lane arithmetic, and ready
//  returns as their result is merged into the output register; a step in air
//  runs the 64-step restoring divider in each lane, which zero mass skips;
//  laminar drag adds the force multiply, turbulent drag adds the shared 32-step
//  square root and the drag coefficient multiply.
//  reset zeroes position and velocity and loads register defaults.
//  one result waits in the output register while the next item runs.
module particle_integrator_with_drag_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [111:0]  s_axis_tdata,   // dt, vec_x, vec_y, vec_z
  input  logic [1:0]    s_axis_tuser,   // req_type
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [199:0]  m_axis_tdata,   // pos_x/y/z, vel_x/y/z, saturated
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [31:0]   cfg_wdata_i
);
  import pid_pkg::*;

  logic               in_fluid_q, laminar_q;
  logic [30:0]        k_q, mass_q;
  logic signed [31:0] fext_q [3];
  logic [15:0]        dt_q;
  top_state_e         st_q, st_d;
  logic [63:0]        sum_q;
  logic [62:0]        cprod_q;
  logic [46:0]        c_q;
  logic               m_valid_q;
  logic [192:0]       out_q;

  lane_ctrl_t ctrl;
  lane_stat_t stat [3];
  logic       accept, all_sq, all_done, merge, sq_start, sq_done;
  logic [31:0] root;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign all_sq   = stat[0].sq_done && stat[1].sq_done && stat[2].sq_done;
  assign all_done = stat[0].done && stat[1].done && stat[2].done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_fluid_q <= 1'b0;
      laminar_q  <= 1'b1;
      k_q        <= '0;
      mass_q     <= 31'd65536;
      fext_q[0]  <= '0;
      fext_q[1]  <= '0;
      fext_q[2]  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IN_FLUID: in_fluid_q <= cfg_wdata_i[0];
        CFG_LAMINAR:  laminar_q  <= cfg_wdata_i[0];
        CFG_DRAG:     k_q        <= cfg_wdata_i[30:0];
        CFG_MASS:     mass_q     <= cfg_wdata_i[30:0];
        CFG_EXT_FX:   fext_q[0]  <= cfg_wdata_i;
        CFG_EXT_FY:   fext_q[1]  <= cfg_wdata_i;
        CFG_EXT_FZ:   fext_q[2]  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    st_d     = st_q;
    merge    = 1'b0;
    sq_start = 1'b0;
    unique case (st_q)
      T_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == REQ_STEP && in_fluid_q && !laminar_q) st_d = T_SQWAIT;
          else st_d = T_WAIT;
        end
      end
      T_SQWAIT: if (all_sq) st_d = T_SQGO;
      T_SQGO: begin
        sq_start = 1'b1;
        st_d     = T_SQRT;
      end
      T_SQRT:   if (sq_done) st_d = T_CMUL;
      T_CMUL:   st_d = T_CRND;
      T_CRND:   st_d = T_CGO;
      T_CGO:    st_d = T_WAIT;
      T_WAIT: begin
        if (all_done && (!m_valid_q || m_axis_tready)) begin
          merge = 1'b1;
          st_d  = T_IDLE;
        end
      end
      default:  st_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= T_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (merge) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) dt_q <= s_axis_tdata[15:0];
    if (st_q == T_SQWAIT) sum_q <= stat[0].sq + stat[1].sq + stat[2].sq;
    if (st_q == T_CMUL) cprod_q <= k_q * root;
    if (st_q == T_CRND) c_q <= cprod_q[62:16] + 47'(cprod_q[15]);
    if (merge) begin
      out_q <= {stat[0].sat | stat[1].sat | stat[2].sat,
                stat[2].vel, stat[1].vel, stat[0].vel,
                stat[2].pos, stat[1].pos, stat[0].pos};
    end
  end

  pid_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .x_i     (sum_q),
    .done_o  (sq_done),
    .root_o  (root)
  );

  assign ctrl.start    = accept;
  assign ctrl.op       = req_e'(s_axis_tuser);
  assign ctrl.ack      = merge;
  assign ctrl.c_valid  = (st_q == T_CGO);
  assign ctrl.c        = c_q;
  assign ctrl.in_fluid = in_fluid_q;
  assign ctrl.laminar  = laminar_q;
  assign ctrl.k        = k_q;
  assign ctrl.mass     = mass_q;
  assign ctrl.dt       = dt_q;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    pid_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .force_i (fext_q[g]),
      .vec_i   (s_axis_tdata[16+32*g +: 32]),
      .stat_o  (stat[g])
    );
  end

  assign s_axis_tready = (st_q == T_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'b0, out_q};

endmodule

// ===== design/pid_checker.sv =====
// ----------------------------------------------------------------------------
// pid_checker
// Port-level checks on the integrator handshakes and result ordering.
// ----------------------------------------------------------------------------
module pid_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [199:0] m_axis_tdata
);
  import pid_pkg::*;

  // one item in flight: ready drops after each accepted transaction
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  // a new result only appears as the running item finishes
  a_result_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without an item in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind particle_integrator_with_drag_unit pid_checker u_pid_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
